// ===== hw/rtl/bc_pkg.sv =====
// shared types and constants for the binomial coefficient unit
`timescale 1ns / 1ps

package bc_pkg;

    localparam int unsigned N_W      = 6;
    localparam int unsigned COEF_W   = 30;
    localparam int unsigned MAX_N    = 32;
    localparam int unsigned ACC_W    = (MAX_N > COEF_W) ? MAX_N : COEF_W;
    localparam int unsigned PROD_W   = ACC_W + N_W;
    localparam int unsigned CNT_W    = $clog2(PROD_W);

    localparam logic [COEF_W-1:0] COEF_MAX = {COEF_W{1'b1}};

    typedef struct packed {
        logic load;
        logic init;
        logic mul;
        logic div;
        logic next;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic iter_done;
        logic div_last;
    } t_status;

endpackage

// ===== hw/rtl/bc_dpath.sv =====
// datapath: operand registers, multiplier and bit-serial exact divider
`timescale 1ns / 1ps

module bc_dpath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bc_pkg::t_cmd                i_cmd,
    output bc_pkg::t_status             o_status,
    input  logic [bc_pkg::N_W-1:0]      i_n_total,
    input  logic [bc_pkg::N_W-1:0]      i_k_chosen,
    output logic [bc_pkg::COEF_W-1:0]   o_coefficient,
    output logic                        o_range_error
);

    logic [bc_pkg::N_W-1:0]    r_n;
    logic [bc_pkg::N_W-1:0]    r_k;
    logic [bc_pkg::N_W-1:0]    r_i;
    logic [bc_pkg::N_W-1:0]    r_rem;
    logic [bc_pkg::ACC_W-1:0]  r_acc;
    logic [bc_pkg::PROD_W-1:0] r_quo;
    logic [bc_pkg::CNT_W-1:0]  r_cnt;
    logic                      r_err;
    logic [bc_pkg::COEF_W-1:0] r_coef;
    logic                      r_range;

    logic                      range_hit;
    logic                      k_big;
    logic                      trivial;
    logic                      use_sym;
    logic [bc_pkg::N_W-1:0]    k_eff;
    logic [bc_pkg::N_W-1:0]    first_val;
    logic [bc_pkg::N_W-1:0]    factor;
    logic [bc_pkg::PROD_W-1:0] product;
    logic [bc_pkg::N_W:0]      rem_sh;
    logic                      q_bit;
    logic [bc_pkg::N_W-1:0]    rem_nxt;

    // operand classification
    assign range_hit = r_n > bc_pkg::N_W'(bc_pkg::MAX_N);
    assign k_big     = r_k > r_n;
    assign trivial   = (r_k == '0) || (r_k == r_n);
    assign use_sym   = {r_k, 1'b0} > {1'b0, r_n};
    assign k_eff     = use_sym ? (r_n - r_k) : r_k;
    assign first_val = r_n - k_eff + bc_pkg::N_W'(1);

    // recurrence factor n-k+i and product
    assign factor  = r_n - r_k + r_i;
    assign product = bc_pkg::PROD_W'(r_acc) * bc_pkg::PROD_W'(factor);

    // one restoring division step
    assign rem_sh  = {r_rem, r_quo[bc_pkg::PROD_W-1]};
    assign q_bit   = rem_sh >= {1'b0, r_i};
    assign rem_nxt = q_bit ? bc_pkg::N_W'(rem_sh - {1'b0, r_i}) : rem_sh[bc_pkg::N_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_n <= i_n_total;
            r_k <= i_k_chosen;
        end
        if (i_cmd.init) begin
            r_err <= range_hit;
            r_i   <= bc_pkg::N_W'(2);
            if (range_hit || k_big) begin
                r_acc <= '0;
                r_k   <= '0;
            end else if (trivial) begin
                r_acc <= bc_pkg::ACC_W'(1);
                r_k   <= '0;
            end else begin
                r_acc <= bc_pkg::ACC_W'(first_val);
                r_k   <= k_eff;
            end
        end
        if (i_cmd.mul) begin
            r_quo <= product;
            r_rem <= '0;
            r_cnt <= '0;
        end
        if (i_cmd.div) begin
            r_quo <= {r_quo[bc_pkg::PROD_W-2:0], q_bit};
            r_rem <= rem_nxt;
            r_cnt <= r_cnt + bc_pkg::CNT_W'(1);
        end
        if (i_cmd.next) begin
            r_acc <= r_quo[bc_pkg::ACC_W-1:0];
            r_i   <= r_i + bc_pkg::N_W'(1);
        end
        if (i_cmd.out_load) begin
            r_coef  <= (r_acc > bc_pkg::ACC_W'(bc_pkg::COEF_MAX)) ? bc_pkg::COEF_MAX
                                                                 : r_acc[bc_pkg::COEF_W-1:0];
            r_range <= r_err;
        end
    end

    assign o_status.iter_done = r_i > r_k;
    assign o_status.div_last  = r_cnt == bc_pkg::CNT_W'(bc_pkg::PROD_W - 1);
    assign o_coefficient      = r_coef;
    assign o_range_error      = r_range;

    // partial remainder always below the divisor
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div |-> (r_rem < r_i))
        else $error("divider remainder not below divisor");

    // every division of the recurrence is exact
    a_exact_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.next |-> (r_rem == '0))
        else $error("nonzero remainder in exact division");

    // out of range operand yields zero
    a_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.out_load && r_err) |=> (o_range_error && (o_coefficient == '0)))
        else $error("range error with nonzero coefficient");

endmodule

// ===== hw/rtl/bc_ctrl.sv =====
// controller: sequencing of the recurrence and output register handshake
`timescale 1ns / 1ps

module bc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  bc_pkg::t_status  i_status,
    output bc_pkg::t_cmd     o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_INIT = 3'd1;
    localparam logic [2:0] S_LOOP = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_NEXT = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_INIT;
                end
            end
            S_INIT: begin
                o_cmd.init = 1'b1;
                n_state    = S_LOOP;
            end
            S_LOOP: begin
                if (i_status.iter_done) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.mul = 1'b1;
                    n_state   = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_NEXT;
                end
            end
            S_NEXT: begin
                o_cmd.next = 1'b1;
                n_state    = S_LOOP;
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_out_valid;

    // accepted transaction starts setup next cycle
    a_accept_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_INIT))
        else $error("accepted transaction did not enter setup");

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("output register overwritten");

    // divider runs only between a multiply and an update
    a_div_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NEXT) |-> $past(r_state == S_DIV))
        else $error("update without division");

endmodule

// ===== hw/rtl/binomial_coefficient.sv =====
// top level of the binomial coefficient unit
//
//  channel  direction  handshake                   payload
//  in       input      i_in_valid / o_in_ready     i_n_total, i_k_chosen
//  out      output     o_out_valid / i_out_ready   o_coefficient, o_range_error
//
//  one transaction runs k'-1 multiply and divide steps, k' = min(k, n-k);
//  each divide step yields PROD_W = 38 quotient bits from the one-bit-a-cycle divider
//  special cases (k = 0, k = n, k > n, n > MAX_N) skip the multiply and divide steps
//  synchronous active-low reset clears the controller and the output valid
//  a new transaction is taken while a finished result waits in the output register
`timescale 1ns / 1ps

module binomial_coefficient (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [bc_pkg::N_W-1:0]      i_n_total,
    input  logic [bc_pkg::N_W-1:0]      i_k_chosen,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [bc_pkg::COEF_W-1:0]   o_coefficient,
    output logic                        o_range_error
);

    bc_pkg::t_cmd    cmd;
    bc_pkg::t_status status;

    bc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    bc_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_n_total     (i_n_total),
        .i_k_chosen    (i_k_chosen),
        .o_coefficient (o_coefficient),
        .o_range_error (o_range_error)
    );

endmodule
